// ===== sv/rtc3w_pkg.sv =====
// Types, codes and BCD helper functions shared by the three-wire clock master.
package rtc3w_pkg;

    // Kind of input transfer (carried on tuser)
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Time field selectors
    localparam logic [2:0] FIELD_SECOND = 3'd0;
    localparam logic [2:0] FIELD_MINUTE = 3'd1;
    localparam logic [2:0] FIELD_HOUR   = 3'd2;
    localparam logic [2:0] FIELD_DAY    = 3'd3;
    localparam logic [2:0] FIELD_DATE   = 3'd4;
    localparam logic [2:0] FIELD_MONTH  = 3'd5;
    localparam logic [2:0] FIELD_YEAR   = 3'd6;
    localparam logic [2:0] FIELD_NONE   = 3'd7;

    // Hour modes
    localparam logic [1:0] HF_24H    = 2'd0;
    localparam logic [1:0] HF_12H_AM = 2'd1;
    localparam logic [1:0] HF_12H_PM = 2'd2;
    localparam logic [1:0] HF_BAD    = 2'd3;

    // BCD tens masks and flag bits
    localparam logic [7:0] TENS_SEC   = 8'h70;
    localparam logic [7:0] TENS_DATE  = 8'h30;
    localparam logic [7:0] TENS_MONTH = 8'h10;
    localparam logic [7:0] TENS_YEAR  = 8'hF0;
    localparam logic [7:0] ONES_MASK  = 8'h0F;
    localparam logic [7:0] FLAG_12H   = 8'h80;
    localparam logic [7:0] FLAG_12PM  = 8'hA0;
    localparam logic [7:0] DAY_MASK   = 8'h07;
    localparam int unsigned PM_BIT    = 5;
    localparam int unsigned MODE_BIT  = 7;

    // Command byte base; register index in bits 5:1, read flag in bit 0
    localparam logic [7:0] CMD_BASE = 8'h80;

    localparam int unsigned PHASE_W    = 5;
    localparam logic [4:0]  LAST_PHASE = 5'd15;

    localparam int unsigned OUT_W = 16;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] field;
        logic [6:0] value;
        logic [1:0] hr_mode;
        logic       io_in;
    } item_t;

    typedef struct packed {
        logic [1:0] read_hr_mode;
        logic [7:0] read_value;
        logic       done_res;
        logic       busy_res;
        logic       chip_enable;
        logic       io_drive;
        logic       io_out;
        logic       sclk;
    } result_t;

    // Binary to BCD; tens by reciprocal multiply (exact for v below 128)
    function automatic logic [7:0] bcd_encode(input logic [6:0] v, input logic [7:0] tens_mask);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [3:0]  ones;
        prod     = 15'(v) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'({3'b000, tens} * 7'd10);
        ones     = 4'(v - tens_x10);
        return ((8'(tens) << 4) & tens_mask) | {4'b0000, ones};
    endfunction

    function automatic logic [7:0] bcd_decode(input logic [7:0] b, input logic [7:0] tens_mask);
        logic [3:0] tens;
        tens = 4'((b & tens_mask) >> 4);
        return (b & ONES_MASK) + 8'(8'(tens) * 8'd10);
    endfunction

    function automatic logic [7:0] cmd_code(input logic [2:0] field, input logic rd);
        logic [4:0] idx;
        case (field)
            FIELD_SECOND: idx = 5'd0;
            FIELD_MINUTE: idx = 5'd1;
            FIELD_HOUR:   idx = 5'd2;
            FIELD_DAY:    idx = 5'd5;
            FIELD_DATE:   idx = 5'd3;
            FIELD_MONTH:  idx = 5'd4;
            default:      idx = 5'd6;
        endcase
        return CMD_BASE | {2'b00, idx, rd};
    endfunction

    function automatic logic [7:0] write_data(input logic [2:0] field, input logic [6:0] v,
                                              input logic [1:0] hf);
        logic [7:0] d;
        case (field)
            FIELD_SECOND, FIELD_MINUTE: d = bcd_encode(v, TENS_SEC);
            FIELD_HOUR:
            begin
                case (hf)
                    HF_12H_AM: d = bcd_encode(v, TENS_MONTH) | FLAG_12H;
                    HF_12H_PM: d = bcd_encode(v, TENS_MONTH) | FLAG_12PM;
                    default:   d = bcd_encode(v, TENS_DATE);
                endcase
            end
            FIELD_DAY:    d = {1'b0, v} & DAY_MASK;
            FIELD_DATE:   d = bcd_encode(v, TENS_DATE);
            FIELD_MONTH:  d = bcd_encode(v, TENS_MONTH);
            default:      d = bcd_encode(v, TENS_YEAR);
        endcase
        return d;
    endfunction

endpackage

// ===== sv/rtc3w_core.sv =====
// Transfer state and single-pass next-state and pin logic for one input item.
module rtc3w_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rtc3w_pkg::item_t  item,
    output rtc3w_pkg::result_t result
);

    logic       active_reg, active_next;
    logic       is_read_reg, is_read_next;
    logic [2:0] field_reg, field_next;
    logic [rtc3w_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic       clk_high_reg, clk_high_next;
    logic [15:0] shift_out_reg, shift_out_next;
    logic [7:0] shift_in_reg, shift_in_next;
    logic [7:0] dec_value_reg, dec_value_next;
    logic [1:0] dec_format_reg, dec_format_next;

    logic is_req;
    logic rd_req;
    logic start;
    logic tick;
    logic data_phase;
    logic done;
    logic drive;

    assign is_req = (item.mode == rtc3w_pkg::MODE_READ) || (item.mode == rtc3w_pkg::MODE_WRITE);
    assign rd_req = (item.mode == rtc3w_pkg::MODE_READ);
    assign start  = is_req && !active_reg && (item.field != rtc3w_pkg::FIELD_NONE)
                    && !(!rd_req && item.field == rtc3w_pkg::FIELD_HOUR
                         && item.hr_mode == rtc3w_pkg::HF_BAD);
    assign tick   = (item.mode == rtc3w_pkg::MODE_TICK) && active_reg;
    assign data_phase = is_read_reg && (phase_reg[4] || phase_reg[3]);

    always_comb
    begin
        active_next     = active_reg;
        is_read_next    = is_read_reg;
        field_next      = field_reg;
        phase_next      = phase_reg;
        clk_high_next   = clk_high_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        dec_value_next  = dec_value_reg;
        dec_format_next = dec_format_reg;
        done            = 1'b0;

        if (start)
        begin
            active_next    = 1'b1;
            is_read_next   = rd_req;
            field_next     = item.field;
            phase_next     = '0;
            clk_high_next  = 1'b0;
            shift_in_next  = '0;
            shift_out_next = {rd_req ? 8'h00
                                     : rtc3w_pkg::write_data(item.field, item.value,
                                                             item.hr_mode),
                              rtc3w_pkg::cmd_code(item.field, rd_req)};
        end
        else if (tick)
        begin
            if (!clk_high_reg)
            begin
                // rising edge: sample the pin during the read data phase
                if (data_phase)
                    shift_in_next = {item.io_in, shift_in_reg[7:1]};
                clk_high_next = 1'b1;
            end
            else
            begin
                clk_high_next  = 1'b0;
                shift_out_next = shift_out_reg >> 1;
                phase_next     = phase_reg + 1'b1;
                if (phase_reg == rtc3w_pkg::LAST_PHASE)
                begin
                    active_next = 1'b0;
                    phase_next  = '0;
                    done        = 1'b1;
                    if (is_read_reg)
                    begin
                        case (field_reg)
                            rtc3w_pkg::FIELD_SECOND, rtc3w_pkg::FIELD_MINUTE:
                                dec_value_next = rtc3w_pkg::bcd_decode(shift_in_reg,
                                                                       rtc3w_pkg::TENS_SEC);
                            rtc3w_pkg::FIELD_HOUR:
                            begin
                                if (shift_in_reg[rtc3w_pkg::MODE_BIT])
                                begin
                                    dec_format_next = shift_in_reg[rtc3w_pkg::PM_BIT]
                                                      ? rtc3w_pkg::HF_12H_PM
                                                      : rtc3w_pkg::HF_12H_AM;
                                    dec_value_next  = rtc3w_pkg::bcd_decode(shift_in_reg,
                                                                 rtc3w_pkg::TENS_MONTH);
                                end
                                else
                                begin
                                    dec_format_next = rtc3w_pkg::HF_24H;
                                    dec_value_next  = rtc3w_pkg::bcd_decode(shift_in_reg,
                                                                 rtc3w_pkg::TENS_DATE);
                                end
                            end
                            rtc3w_pkg::FIELD_DAY:
                                dec_value_next = shift_in_reg & rtc3w_pkg::DAY_MASK;
                            rtc3w_pkg::FIELD_DATE:
                                dec_value_next = rtc3w_pkg::bcd_decode(shift_in_reg,
                                                                       rtc3w_pkg::TENS_DATE);
                            rtc3w_pkg::FIELD_MONTH:
                                dec_value_next = rtc3w_pkg::bcd_decode(shift_in_reg,
                                                                       rtc3w_pkg::TENS_MONTH);
                            default:
                                dec_value_next = rtc3w_pkg::bcd_decode(shift_in_reg,
                                                                       rtc3w_pkg::TENS_YEAR);
                        endcase
                    end
                end
            end
        end
    end

    // Pin levels follow the state left by this item
    assign drive = active_next && !(is_read_next && (phase_next[4] || phase_next[3]));

    always_comb
    begin
        result.sclk         = clk_high_next;
        result.io_out       = drive & shift_out_next[0];
        result.io_drive     = drive;
        result.chip_enable  = active_next;
        result.busy_res     = active_next;
        result.done_res     = done;
        result.read_value   = dec_value_next;
        result.read_hr_mode = dec_format_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            is_read_reg    <= 1'b0;
            field_reg      <= '0;
            phase_reg      <= '0;
            clk_high_reg   <= 1'b0;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            dec_value_reg  <= '0;
            dec_format_reg <= '0;
        end
        else if (step)
        begin
            active_reg     <= active_next;
            is_read_reg    <= is_read_next;
            field_reg      <= field_next;
            phase_reg      <= phase_next;
            clk_high_reg   <= clk_high_next;
            shift_out_reg  <= shift_out_next;
            shift_in_reg   <= shift_in_next;
            dec_value_reg  <= dec_value_next;
            dec_format_reg <= dec_format_next;
        end
    end

endmodule

// ===== sv/rtc3w_out_buf.sv =====
// Two-entry result register with skid stage between core and output stream.
module rtc3w_out_buf #(
    parameter int unsigned WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             main_valid_reg, main_valid_next;
    logic [WIDTH-1:0] main_data_reg, main_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg, skid_data_next;
    logic             push;
    logic             pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                // advance the held result
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = in_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== sv/rtc_three_wire_bcd_master_top.sv =====
// Top level of the three-wire clock-chip master with BCD field coding.
//
//  channel   dir  tdata                                         tuser
//  s_axis    in   field, value, hr_mode, io_in (16 bits)        mode (2 bits)
//  m_axis    out  pins, flags, read_value, read_hr_mode         -
//
// One result per input transfer; a transfer can be taken every cycle while s_axis_tready is high.
// The result is registered in the main result register (or in the skid stage while it is full) before m_axis.
// A skid stage keeps s_axis_tready high while one result waits; it drops only
// when two results are held.
// Reset clears the transfer state and the decoded read value and hour mode.
module rtc_three_wire_bcd_master_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // field[2:0], value[9:3], hr_mode[11:10],
                                        // io_in[12], zero[15:13]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // sclk[0], io_out[1], io_drive[2], chip_enable[3],
                                        // busy_res[4], done_res[5], read_value[13:6],
                                        // read_hr_mode[15:14]
);

    rtc3w_pkg::item_t   item;
    rtc3w_pkg::result_t result;
    logic               step;
    logic [rtc3w_pkg::OUT_W-1:0] res_data;

    assign step = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item.mode    = s_axis_tuser;
        item.field   = s_axis_tdata[2:0];
        item.value   = s_axis_tdata[9:3];
        item.hr_mode = s_axis_tdata[11:10];
        item.io_in   = s_axis_tdata[12];
    end

    rtc3w_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    assign res_data = {result.read_hr_mode, result.read_value, result.done_res,
                       result.busy_res, result.chip_enable, result.io_drive,
                       result.io_out, result.sclk};

    rtc3w_out_buf #(
        .WIDTH (rtc3w_pkg::OUT_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (res_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result held");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted transfer left no result");

    a_drive_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        result.io_drive |-> result.chip_enable)
        else $error("data pin driven outside a transfer");

    a_done_ends_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        result.done_res |-> (!result.chip_enable && !result.sclk))
        else $error("done raised while transfer still open");

endmodule
